/* rtl/first_fit_bump_allocator_core_defines.svh */
// Assertion macros for the first-fit allocator core.
// Included by the top level; no other dependencies.
`ifndef FIRST_FIT_BUMP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BUMP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FFBA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/ffba_pkg.sv */
// Package for the first-fit allocator core: sizes, codes and FSM states.
// No dependencies.
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 12;

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned OFF_W   = 33;
  localparam int unsigned BYTES_W = 25;
  localparam int unsigned TDATA_W = ((SIZE_W + ADDR_W + 7) / 8) * 8;

  localparam logic [63:0] ADDR_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } ffba_req_e;

  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_SPAN = 1'b1
  } ffba_cfg_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } ffba_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BUMP,
    S_LIMIT,
    S_RESP
  } ffba_state_e;

endpackage

/* rtl/first_fit_bump_allocator_core.sv */
// First-fit heap allocator bookkeeping core: block table, scan sequencer, bump pointer.
// Depends on ffba_pkg and first_fit_bump_allocator_core_defines.svh.
//
//   channel   dir  fields (low bit first)
//   s_axis    in   tuser: req_type | tdata: req_size, free_addr
//   m_axis    out  tuser: status   | tdata: result_addr
//   cfg       in   cfg_idx_i 0 heap base, 1 heap span; cfg_wdata_i
//
// One word at a time. A free of address 0 goes straight to the response step. A scan
// stops at the first hit, a scan miss compares all block_count entries, and an
// allocate that misses on a table that is not full then goes through the bump and
// limit steps, which move the heap end unless out of memory. The scan reads one
// table entry per cycle through the single read port of the block table.
// Reset zeroes the count and sets the heap end to HEADER_BYTES; the table itself needs no pass.
// A result waiting on m_axis holds the sequencer in its response step.
`include "first_fit_bump_allocator_core_defines.svh"

module first_fit_bump_allocator_core
  import ffba_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [ADDR_W-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // req_size[23:0], free_addr[55:24]
  input  logic [0:0]         s_axis_tuser,   // req_type[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ADDR_W-1:0]  m_axis_tdata,   // result_addr[31:0]
  output logic [1:0]         m_axis_tuser    // status[1:0]
);

  ffba_state_e state_q, state_d;

  logic [ADDR_W-1:0]  base_q, base_d;
  logic [ADDR_W-1:0]  span_q, span_d;
  logic               req_free_q, req_free_d;
  logic [BYTES_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [CNT_W-1:0]   blk_cnt_q, blk_cnt_d;
  logic [OFF_W-1:0]   bump_q, bump_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [OFF_W:0]     end_q, end_d;
  logic [OFF_W-1:0]   pay_q, pay_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  ffba_status_e       res_status_q, res_status_d;
  logic               out_vld_q, out_vld_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  ffba_status_e       out_status_q, out_status_d;

  // block table
  logic [OFF_W-1:0]   off_mem   [MAX_BLOCKS];
  logic [BYTES_W-1:0] bytes_mem [MAX_BLOCKS];
  logic               free_mem  [MAX_BLOCKS];
  logic [OFF_W-1:0]   rd_off_q;
  logic [BYTES_W-1:0] rd_bytes_q;
  logic               rd_free_q;
  logic               off_we, bytes_we, free_we, free_wdata;
  logic [IDX_W-1:0]   wr_idx;

  logic               in_acc, out_free, scan_more, table_full;
  logic               alloc_hit, free_hit, cmp_hit, oom;
  logic [BYTES_W-1:0] size_rnd;
  logic [OFF_W:0]     abs_off;
  logic [OFF_W+1:0]   lim_abs;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_vld_q || m_axis_tready;
  assign scan_more  = rd_idx_q < blk_cnt_q;
  assign table_full = blk_cnt_q == CNT_W'(MAX_BLOCKS);
  assign size_rnd   = ({1'b0, s_axis_tdata[SIZE_W-1:0]} + BYTES_W'(3)) & ~BYTES_W'(3);

  // shared compare unit: one table entry per cycle
  assign abs_off   = (OFF_W+1)'(base_q) + (OFF_W+1)'(rd_off_q);
  assign alloc_hit = rd_free_q && (rd_bytes_q >= size_q);
  assign free_hit  = abs_off == (OFF_W+1)'(addr_q);
  assign cmp_hit   = cmp_vld_q && (req_free_q ? free_hit : alloc_hit);

  assign lim_abs = (OFF_W+2)'(base_q) + (OFF_W+2)'(end_q);
  assign oom     = (end_q > (OFF_W+1)'(span_q)) || (lim_abs > (OFF_W+2)'(ADDR_MAX));

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser[0] == REQ_FREE && s_axis_tdata[SIZE_W +: ADDR_W] == '0) begin
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_hit) begin
          state_d = S_RESP;
        end else if (!scan_more && !cmp_vld_q) begin
          state_d = (req_free_q || table_full) ? S_RESP : S_BUMP;
        end
      end
      S_BUMP:  state_d = S_LIMIT;
      S_LIMIT: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    base_d       = base_q;
    span_d       = span_q;
    req_free_d   = req_free_q;
    size_d       = size_q;
    addr_d       = addr_q;
    blk_cnt_d    = blk_cnt_q;
    bump_d       = bump_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    end_d        = end_q;
    pay_d        = pay_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    off_we       = 1'b0;
    bytes_we     = 1'b0;
    free_we      = 1'b0;
    free_wdata   = 1'b0;
    wr_idx       = cmp_idx_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE: base_d = cfg_wdata_i;
        CFG_SPAN: span_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_free_d   = s_axis_tuser[0] == REQ_FREE;
          size_d       = size_rnd;
          addr_d       = s_axis_tdata[SIZE_W +: ADDR_W];
          rd_idx_d     = '0;
          cmp_vld_d    = 1'b0;
          res_addr_d   = '0;
          res_status_d = ST_DONE;
        end
      end
      S_SCAN: begin
        cmp_vld_d = scan_more && !cmp_hit;
        cmp_idx_d = rd_idx_q[IDX_W-1:0];
        if (scan_more && !cmp_hit) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (cmp_hit) begin
          free_we      = 1'b1;
          free_wdata   = req_free_q;
          res_addr_d   = req_free_q ? '0 : abs_off[ADDR_W-1:0];
          res_status_d = ST_DONE;
        end else if (!scan_more && !cmp_vld_q) begin
          res_addr_d = '0;
          if (req_free_q) begin
            res_status_d = ST_UNKNOWN;
          end else if (table_full) begin
            res_status_d = ST_FULL;
          end
        end
      end
      S_BUMP: begin
        end_d = {1'b0, bump_q} + (OFF_W+1)'(HEADER_BYTES) + (OFF_W+1)'(size_q);
        pay_d = bump_q + OFF_W'(HEADER_BYTES);
      end
      S_LIMIT: begin
        wr_idx = blk_cnt_q[IDX_W-1:0];
        if (oom) begin
          res_addr_d   = '0;
          res_status_d = ST_OOM;
        end else begin
          off_we       = 1'b1;
          bytes_we     = 1'b1;
          free_we      = 1'b1;
          free_wdata   = 1'b0;
          blk_cnt_d    = blk_cnt_q + 1'b1;
          bump_d       = end_q[OFF_W-1:0];
          res_addr_d   = base_q + pay_q[ADDR_W-1:0];
          res_status_d = ST_DONE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      base_q    <= '0;
      span_q    <= '0;
      blk_cnt_q <= '0;
      bump_q    <= OFF_W'(HEADER_BYTES);
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      span_q    <= span_d;
      blk_cnt_q <= blk_cnt_d;
      bump_q    <= bump_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_free_q   <= req_free_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    end_q        <= end_d;
    pay_q        <= pay_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[wr_idx] <= pay_q;
    end
    if (bytes_we) begin
      bytes_mem[wr_idx] <= size_q;
    end
    if (free_we) begin
      free_mem[wr_idx] <= free_wdata;
    end
    rd_off_q   <= off_mem[rd_idx_q[IDX_W-1:0]];
    rd_bytes_q <= bytes_mem[rd_idx_q[IDX_W-1:0]];
    rd_free_q  <= free_mem[rd_idx_q[IDX_W-1:0]];
  end

  `FFBA_ASSERT(a_cnt_bound, blk_cnt_q <= CNT_W'(MAX_BLOCKS), "block count above table depth")
  `FFBA_ASSERT(a_cnt_step, blk_cnt_q != $past(blk_cnt_q) |-> blk_cnt_q == $past(blk_cnt_q) + 1'b1, "block count moved by other than one")
  `FFBA_ASSERT(a_cmp_live, cmp_vld_q |-> cmp_idx_q < blk_cnt_q, "scan compared an unwritten entry")
  `FFBA_NEVER(a_bump_mono, bump_q < $past(bump_q), "heap end moved down")

endmodule

/* sim/tb.sv */
// Self-checking bench for first_fit_bump_allocator_core: directed and random allocate/free
// words checked against a built-in first-fit heap predictor.
// Depends on ffba_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import ffba_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASE_WORDS   = 144;
  localparam int unsigned NUM_PHASES    = 8;
  localparam logic [63:0] ALIGN_MASK    = 64'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    ffba_status_e      status;
  } grant_t;

  class heap_scoreboard;
    logic [ADDR_W-1:0]  heap_base;
    logic [ADDR_W-1:0]  heap_cap;
    logic [OFF_W-1:0]   blk_off [MAX_BLOCKS];
    logic [BYTES_W-1:0] blk_len [MAX_BLOCKS];
    bit                 blk_released [MAX_BLOCKS];
    int unsigned        blk_used;
    logic [OFF_W-1:0]   bump_end;
    grant_t             grants [$];
    int unsigned        mismatches;

    function new();
      heap_base  = '0;
      heap_cap   = '0;
      blk_used   = 0;
      bump_end   = OFF_W'(HEADER_BYTES);
      mismatches = 0;
    endfunction

    function void set_reg(ffba_cfg_e idx, logic [ADDR_W-1:0] value);
      if (idx == CFG_BASE) heap_base = value;
      else heap_cap = value;
    endfunction

    // payload address of a table entry under the current base, cut to 32 bits
    function logic [ADDR_W-1:0] entry_addr(int unsigned i);
      return ADDR_W'(64'(heap_base) + 64'(blk_off[i]));
    endfunction

    function void note_request(ffba_req_e kind, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      logic [63:0] rounded;
      logic [63:0] need;
      grant_t      g;
      g.addr   = '0;
      g.status = ST_DONE;
      if (kind == REQ_FREE) begin
        if (addr != '0) begin
          g.status = ST_UNKNOWN;
          // match on the full sum: an entry pushed past 4G by a new base never matches
          for (int unsigned i = 0; i < blk_used; i++) begin
            if (64'(heap_base) + 64'(blk_off[i]) == 64'(addr)) begin
              blk_released[i] = 1'b1;
              g.status = ST_DONE;
              break;
            end
          end
        end
        grants.push_back(g);
        return;
      end
      rounded = (64'(size) + ALIGN_MASK) & ~ALIGN_MASK;
      for (int unsigned i = 0; i < blk_used; i++) begin
        if (blk_released[i] && 64'(blk_len[i]) >= rounded) begin
          blk_released[i] = 1'b0;
          g.addr = entry_addr(i);
          grants.push_back(g);
          return;
        end
      end
      need = 64'(HEADER_BYTES) + rounded;
      if (blk_used >= MAX_BLOCKS) begin
        g.status = ST_FULL;
      end else if (64'(bump_end) + need > 64'(heap_cap) ||
                   64'(heap_base) + 64'(bump_end) + need > ADDR_MAX) begin
        g.status = ST_OOM;
      end else begin
        blk_off[blk_used]      = OFF_W'(64'(bump_end) + 64'(HEADER_BYTES));
        blk_len[blk_used]      = BYTES_W'(rounded);
        blk_released[blk_used] = 1'b0;
        g.addr = entry_addr(blk_used);
        blk_used++;
        bump_end = OFF_W'(64'(bump_end) + need);
      end
      grants.push_back(g);
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [1:0] status);
      grant_t g;
      if (grants.size() == 0) begin
        $error("result word with nothing outstanding: result_addr %h status %0d",
               addr, status);
        mismatches++;
        return;
      end
      g = grants.pop_front();
      if (addr !== g.addr) begin
        $error("result_addr: expected %h, actual %h", g.addr, addr);
        mismatches++;
      end
      if (status !== g.status) begin
        $error("status: expected %0d, actual %0d", g.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [ADDR_W-1:0]  cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // req_size[23:0], free_addr[55:24]
  logic [0:0]         s_axis_tuser;   // req_type[0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [ADDR_W-1:0]  m_axis_tdata;   // result_addr[31:0]
  logic [1:0]         m_axis_tuser;   // status[1:0]

  heap_scoreboard heap_sb = new();
  int unsigned    src_idle_pct  = 0;
  int unsigned    snk_stall_pct = 0;
  int unsigned    quiet_cycles  = 0;
  bit             hold_request  = 1'b0;

  first_fit_bump_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      heap_sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("first_fit_bump_allocator_core verification failed");
      $finish;
    end
  end

  // result sink: random back-pressure, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_word(ffba_req_e kind, logic [SIZE_W-1:0] size,
                           logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= TDATA_W'({addr, size});
    do @(posedge clk_i); while (!s_axis_tready);
    heap_sb.note_request(kind, size, addr);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (heap_sb.grants.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_heap(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    heap_sb.set_reg(CFG_BASE, base);
    cfg_idx_i   <= CFG_SPAN;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    heap_sb.set_reg(CFG_SPAN, limit);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly frees of live payloads and modest allocations, some noise
  task automatic send_random_word();
    int unsigned       pick;
    int unsigned       n;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    n    = heap_sb.blk_used;
    size = SIZE_W'($urandom);
    addr = $urandom;
    if (pick < 48) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: size = SIZE_W'($urandom_range(64));
        5, 6:          size = SIZE_W'($urandom_range(4096));
        7:             size = SIZE_W'($urandom);
        8:             size = $urandom_range(1) ? SIZE_W'($urandom_range(3))
                                                : SIZE_W'(24'hFFFFFF - $urandom_range(3));
        default: begin
          // exact or near fit against an existing block
          if (n != 0) size = SIZE_W'(heap_sb.blk_len[$urandom_range(n - 1)]
                                     - $urandom_range(3));
        end
      endcase
      send_word(REQ_ALLOC, size, addr);
    end else if (pick < 83 && n != 0) begin
      send_word(REQ_FREE, size, heap_sb.entry_addr($urandom_range(n - 1)));
    end else if (pick < 88) begin
      send_word(REQ_FREE, size, '0);
    end else if (pick < 94 && n != 0) begin
      send_word(REQ_FREE, size, heap_sb.entry_addr($urandom_range(n - 1))
                                ^ (ADDR_W'(1) << $urandom_range(ADDR_W - 1)));
    end else begin
      send_word(REQ_FREE, size, addr);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_BASE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ALLOC;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: empty heap
    send_word(REQ_ALLOC, '0, '0);
    send_word(REQ_FREE, '0, '0);
    send_word(REQ_FREE, 24'hFFFFFF, 32'hFFFFFFFF);

    wait_quiet();
    program_heap(32'h0000_1000, 32'h0000_0100);
    send_word(REQ_ALLOC, 24'd0, '0);          // bare header
    send_word(REQ_ALLOC, 24'd1, '0);
    send_word(REQ_ALLOC, 24'hFFFFFF, '0);     // out of memory
    send_word(REQ_ALLOC, 24'd3, '0);
    send_word(REQ_FREE, '0, heap_sb.entry_addr(0));
    send_word(REQ_FREE, '0, heap_sb.entry_addr(0));   // already free
    send_word(REQ_ALLOC, 24'd5, '0);          // zero-size block too small, bumps
    send_word(REQ_ALLOC, 24'd0, '0);          // takes the zero-size block
    send_word(REQ_FREE, '0, heap_sb.entry_addr(1));
    send_word(REQ_ALLOC, 24'd4, '0);
    send_word(REQ_FREE, '0, heap_sb.entry_addr(1) + 32'd4);  // unmatched
    send_word(REQ_ALLOC, 24'd2, 32'hFFFFFFFF);

    wait_quiet();
    program_heap(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_word(REQ_ALLOC, 24'hFFFFFF, '0);     // would end past 4G
    send_word(REQ_ALLOC, 24'hFFFFFD, '0);     // rounds into bit 24
    send_word(REQ_FREE, '0, heap_sb.entry_addr(0));
    send_word(REQ_ALLOC, 24'd0, '0);
    send_word(REQ_ALLOC, 24'd8, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin base = $urandom;      limit = 32'h0000_0600; end
        1:       begin base = '0;            limit = '0;            end
        2:       begin base = 32'hFFFF_FFFF; limit = 32'hFFFF_FFFF; end
        3:       begin base = 32'hFFFF_0000; limit = 32'hFFFF_FFFF; end
        4:       begin base = '0;            limit = 32'hFFFF_FFFF; end
        5:       begin base = $urandom;      limit = $urandom;      end
        6:       begin base = 32'h8000_0000; limit = 32'h00FF_FFFF; end
        default: begin base = $urandom;      limit = 32'hFFFF_FFFF; end
      endcase
      case (p % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 46; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 46; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase
      wait_quiet();
      program_heap(base, limit);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 0 && k == 20) hold_request = 1'b1;
        send_random_word();
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (heap_sb.mismatches == 0 && heap_sb.grants.size() == 0) begin
      $display("first_fit_bump_allocator_core verification clean");
    end else begin
      $display("first_fit_bump_allocator_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ffba_pkg.sv
rtl/first_fit_bump_allocator_core.sv
sim/tb.sv
